// ===== rtl/core/bfa_pkg.sv =====
package bfa_pkg;

    // Configuration register indexes.
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_UNIT   = 1'b1;

    // Fit policy codes.
    localparam logic [2:0] POL_NONE  = 3'd0;
    localparam logic [2:0] POL_FIRST = 3'd1;
    localparam logic [2:0] POL_NEXT  = 3'd2;
    localparam logic [2:0] POL_BEST  = 3'd3;
    localparam logic [2:0] POL_WORST = 3'd4;

    // Item function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Widths fixed by the item fields.
    localparam int SIZE_W   = 20;
    localparam int USIZE_W  = 16;
    localparam int START_W  = 6;
    localparam int COUNT_W  = 16;
    localparam int DIV_STEPS = 20;
    localparam int STEP_W   = 5;

    localparam logic [USIZE_W-1:0] UNIT_RESET = 16'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_PICK,
        ST_MARK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/bitmap_fit_allocator.sv =====
// Allocate runs the divide, a scan of the ring, a pick and a mark pass over the ring,
// then the result strobe. Free skips the scan and pick; a failing allocate ends after
// the divide or, when no run fits, after the scan and pick. Busy is high from accept
// through the strobe, so a new item is taken only once the last one is done.
// Reset clears the bitmap and rover, sets policy to none and unit size to 16.
module bitmap_fit_allocator #(
    parameter int UNITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [bfa_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [bfa_pkg::START_W-1:0]   free_start,
    output logic                          done,
    output logic                          ok,
    output logic [bfa_pkg::START_W-1:0]   start_unit,
    output logic [bfa_pkg::COUNT_W-1:0]   unit_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [bfa_pkg::USIZE_W-1:0]   cfg_data
);
    import bfa_pkg::*;

    localparam int POS_W  = (UNITS > 2) ? $clog2(UNITS) : 1;
    localparam int LEN_W  = POS_W + 1;
    localparam int CNT_W  = SIZE_W + 1;
    localparam int BASE_W = (POS_W > START_W) ? POS_W : START_W;

    state_t state_reg, state_next;

    logic [2:0]          policy_reg;
    logic [USIZE_W-1:0]  unit_reg;
    logic [POS_W-1:0]    rover_reg;
    logic                func_reg;
    logic [START_W-1:0]  fstart_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [POS_W-1:0]    p_reg;
    logic [LEN_W-1:0]    runb_reg, runa_reg;
    logic [POS_W-1:0]    rsb_reg, rsa_reg;
    logic                fb_found_reg, fa_found_reg, g_found_reg;
    logic [POS_W-1:0]    fb_pos_reg, fa_pos_reg, g_pos_reg;
    logic [LEN_W-1:0]    g_len_reg;
    logic [BASE_W-1:0]   base_reg;
    logic                mark_val_reg;
    logic                ok_reg;
    logic [START_W-1:0]  su_reg;
    logic [COUNT_W-1:0]  uc_reg;

    logic                accept;
    logic                div_done;
    logic [SIZE_W-1:0]   quot;
    logic                rem_nz;
    logic [CNT_W-1:0]    count;
    logic                pol_valid;
    logic                alloc_bad;
    logic                last;
    logic [UNITS-1:0]    ring;
    logic                head_new;
    logic                shift;

    assign accept = start && (state_reg == ST_IDLE);
    assign last   = (p_reg == POS_W'(UNITS - 1));
    assign shift  = (state_reg == ST_SCAN) || (state_reg == ST_MARK);

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_NONE;
            unit_reg   <= UNIT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_POLICY)
            begin
                policy_reg <= cfg_data[2:0];
            end
            else
            begin
                unit_reg <= cfg_data;
            end
        end
    end

    // Ceiling division of the byte size by the unit size.
    bfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (size_bytes),
        .divisor  (unit_reg),
        .done     (div_done),
        .quot     (quot),
        .rem_nz   (rem_nz)
    );

    assign count     = {1'b0, quot} + CNT_W'(rem_nz);
    assign pol_valid = (policy_reg == POL_FIRST) || (policy_reg == POL_NEXT) ||
                       (policy_reg == POL_BEST) || (policy_reg == POL_WORST);
    assign alloc_bad = (count == '0) || (count > CNT_W'(UNITS)) || !pol_valid;

    // Bitmap ring: cell 0 holds the unit under the scan position.
    logic [BASE_W:0] pe;
    logic [BASE_W:0] off;
    logic            in_range;

    always_comb
    begin
        pe       = (BASE_W+1)'(p_reg);
        off      = pe - {1'b0, base_reg};
        in_range = (pe >= {1'b0, base_reg}) && (CNT_W'(off) < cnt_reg);
        head_new = ring[0];
        if ((state_reg == ST_MARK) && in_range)
        begin
            head_new = mark_val_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < UNITS; gi++)
        begin : g_cell
            logic nb;
            if (gi == UNITS - 1)
            begin : g_tail
                assign nb = head_new;
            end
            else
            begin : g_mid
                assign nb = ring[gi+1];
            end
            bfa_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .bit_in  (nb),
                .bit_out (ring[gi])
            );
        end
    endgenerate

    // Scan step: free-run tracking for all fit policies at once.
    logic             h_free, a_free;
    logic [LEN_W-1:0] lenb_new, lena_new, clen;
    logic [POS_W-1:0] rsb_new, rsa_new, cstart;
    logic             fb_hit, fa_hit, g_end, g_take;
    logic             pick_found;
    logic [POS_W-1:0] pick_pos;

    always_comb
    begin
        h_free   = !ring[0];
        a_free   = h_free && (p_reg >= rover_reg);
        lenb_new = h_free ? runb_reg + 1'b1 : '0;
        rsb_new  = (h_free && (runb_reg == '0)) ? p_reg : rsb_reg;
        lena_new = a_free ? runa_reg + 1'b1 : '0;
        rsa_new  = (a_free && (runa_reg == '0)) ? p_reg : rsa_reg;
        fb_hit   = !fb_found_reg && h_free && (CNT_W'(lenb_new) >= cnt_reg);
        fa_hit   = !fa_found_reg && a_free && (CNT_W'(lena_new) >= cnt_reg);
        if (h_free)
        begin
            clen   = lenb_new;
            cstart = rsb_new;
            g_end  = last;
        end
        else
        begin
            clen   = runb_reg;
            cstart = rsb_reg;
            g_end  = (runb_reg != '0);
        end
        g_take = g_end && (CNT_W'(clen) >= cnt_reg) &&
                 (!g_found_reg ||
                  ((policy_reg == POL_BEST) ? (clen < g_len_reg) : (clen > g_len_reg)));
    end

    // Choice of run after the scan.
    always_comb
    begin
        case (policy_reg)
            POL_FIRST:
            begin
                pick_found = fb_found_reg;
                pick_pos   = fb_pos_reg;
            end
            POL_NEXT:
            begin
                pick_found = fa_found_reg || fb_found_reg;
                pick_pos   = fa_found_reg ? fa_pos_reg : fb_pos_reg;
            end
            POL_BEST, POL_WORST:
            begin
                pick_found = g_found_reg;
                pick_pos   = g_pos_reg;
            end
            default:
            begin
                pick_found = 1'b0;
                pick_pos   = '0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (func_reg == FUNC_FREE)
                    begin
                        state_next = ST_MARK;
                    end
                    else if (alloc_bad)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = pick_found ? ST_MARK : ST_DONE;
            end
            ST_MARK:
            begin
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rover_reg <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (shift)
            begin
                p_reg <= last ? '0 : p_reg + 1'b1;
            end
            if ((state_reg == ST_PICK) && (policy_reg == POL_NEXT) && pick_found)
            begin
                rover_reg <= pick_pos;
            end
        end
    end

    // Item datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            fstart_reg   <= free_start;
            runb_reg     <= '0;
            runa_reg     <= '0;
            rsb_reg      <= '0;
            rsa_reg      <= '0;
            fb_found_reg <= 1'b0;
            fa_found_reg <= 1'b0;
            g_found_reg  <= 1'b0;
            fb_pos_reg   <= '0;
            fa_pos_reg   <= '0;
            g_pos_reg    <= '0;
            g_len_reg    <= '0;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            cnt_reg      <= count;
            uc_reg       <= (count > CNT_W'({COUNT_W{1'b1}})) ? '1 : count[COUNT_W-1:0];
            base_reg     <= BASE_W'(fstart_reg);
            mark_val_reg <= 1'b0;
            ok_reg       <= (func_reg == FUNC_FREE);
            su_reg       <= (func_reg == FUNC_FREE) ? fstart_reg : '0;
        end
        if (state_reg == ST_SCAN)
        begin
            runb_reg <= lenb_new;
            rsb_reg  <= rsb_new;
            runa_reg <= lena_new;
            rsa_reg  <= rsa_new;
            if (fb_hit)
            begin
                fb_found_reg <= 1'b1;
                fb_pos_reg   <= rsb_new;
            end
            if (fa_hit)
            begin
                fa_found_reg <= 1'b1;
                fa_pos_reg   <= rsa_new;
            end
            if (g_take)
            begin
                g_found_reg <= 1'b1;
                g_pos_reg   <= cstart;
                g_len_reg   <= clen;
            end
        end
        if (state_reg == ST_PICK)
        begin
            base_reg     <= BASE_W'(pick_pos);
            mark_val_reg <= 1'b1;
            ok_reg       <= pick_found;
            su_reg       <= pick_found ? START_W'(pick_pos) : '0;
        end
    end

    // Outputs.
    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_DONE);
    assign ok         = ok_reg;
    assign start_unit = su_reg;
    assign unit_count = uc_reg;

    // A result beat only comes while an item is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result beat without an item in flight");

    // An accepted item makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start");

    // The ring is back in alignment whenever the block is idle.
    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (p_reg == '0))
        else $error("bitmap ring left out of alignment");

    // A free always reports success.
    a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (func_reg == FUNC_FREE)) |-> ok)
        else $error("free reported failure");
endmodule

// ===== rtl/core/bfa_cell.sv =====
module bfa_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  logic bit_in,
    output logic bit_out
);
    logic used_reg;

    // One unit of the bitmap; moves one place along the ring per shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (shift)
        begin
            used_reg <= bit_in;
        end
    end

    assign bit_out = used_reg;
endmodule

// ===== rtl/core/bfa_div.sv =====
module bfa_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bfa_pkg::SIZE_W-1:0]   dividend,
    input  logic [bfa_pkg::USIZE_W-1:0]  divisor,
    output logic                         done,
    output logic [bfa_pkg::SIZE_W-1:0]   quot,
    output logic                         rem_nz
);
    import bfa_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SIZE_W-1:0]   dq_reg;
    logic [USIZE_W-1:0]  rem_reg;
    logic [USIZE_W-1:0]  dv_reg;
    logic [USIZE_W:0]    shifted;
    logic [USIZE_W:0]    diff;
    logic                ge;
    logic [USIZE_W-1:0]  rem_next;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, dq_reg[SIZE_W-1]};
        ge       = (shifted >= {1'b0, dv_reg});
        diff     = shifted - {1'b0, dv_reg};
        rem_next = ge ? diff[USIZE_W-1:0] : shifted[USIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dv_reg  <= (divisor == '0) ? USIZE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[SIZE_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done   = done_reg;
    assign quot   = dq_reg;
    assign rem_nz = (rem_reg != '0);
endmodule

// ===== tb/bitmap_fit_allocator_test.sv =====
module bitmap_fit_allocator_test;
    import bfa_pkg::*;

    localparam int NUM_UNITS = 64;
    localparam int STALL_LIMIT = 20000;

    // One expected allocator response.
    typedef struct {
        logic                ok;
        logic [START_W-1:0]  start_unit;
        logic [COUNT_W-1:0]  unit_count;
    } alloc_resp_t;

    // Scoreboard: mirrors the bitmap and rover and queues expected responses.
    class alloc_scoreboard;
        logic [2:0]          policy;
        logic [USIZE_W-1:0]  unit_bytes;
        bit                  used[NUM_UNITS];
        int unsigned         rover;
        alloc_resp_t         pending[$];
        int                  mismatches;
        int                  checked;

        function new();
            policy = POL_NONE;
            unit_bytes = UNIT_RESET;
            rover = 0;
            mismatches = 0;
            checked = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [USIZE_W-1:0] data);
            if (idx == REG_POLICY)
                policy = data[2:0];
            else
                unit_bytes = data;
        endfunction

        function bit span_free(int unsigned s, int unsigned n);
            if (s >= NUM_UNITS || n > NUM_UNITS - s)
                return 0;
            for (int unsigned k = s; k < s + n; k++)
                if (used[k])
                    return 0;
            return 1;
        endfunction

        // Best or worst gap among maximal free runs; NUM_UNITS when none.
        function int unsigned gap_pick(int unsigned n, bit want_small);
            int unsigned i, e, len, pick, pick_len;
            i = 0;
            pick = NUM_UNITS;
            pick_len = 0;
            while (i < NUM_UNITS)
            begin
                if (used[i])
                begin
                    i++;
                    continue;
                end
                e = i;
                while (e < NUM_UNITS && !used[e])
                    e++;
                len = e - i;
                if (len >= n && (pick == NUM_UNITS ||
                    (want_small ? len < pick_len : len > pick_len)))
                begin
                    pick = i;
                    pick_len = len;
                end
                i = e;
            end
            return pick;
        endfunction

        // Notes an accepted item and predicts its response.
        function void note_item(logic fn, logic [SIZE_W-1:0] sz,
                                logic [START_W-1:0] fs);
            alloc_resp_t r;
            int unsigned us, cnt, pos, p;
            us = (unit_bytes == 0) ? 1 : unit_bytes;
            cnt = (sz + us - 1) / us;
            r.ok = 0;
            r.start_unit = '0;
            r.unit_count = (cnt > 65535) ? 16'hFFFF : cnt[15:0];
            if (fn == FUNC_FREE)
            begin
                for (int unsigned k = fs; k < NUM_UNITS && k - fs < cnt; k++)
                    used[k] = 0;
                r.ok = 1;
                r.start_unit = fs;
            end
            else if (cnt != 0 && cnt <= NUM_UNITS)
            begin
                pos = NUM_UNITS;
                case (policy)
                    POL_FIRST:
                        for (int unsigned k = 0; k < NUM_UNITS; k++)
                            if (span_free(k, cnt))
                            begin
                                pos = k;
                                break;
                            end
                    POL_NEXT:
                    begin
                        p = rover;
                        for (int unsigned k = 0; k < NUM_UNITS; k++)
                        begin
                            if (span_free(p, cnt))
                            begin
                                pos = p;
                                break;
                            end
                            p = (p + 1 == NUM_UNITS) ? 0 : p + 1;
                        end
                        if (pos < NUM_UNITS)
                            rover = pos;
                    end
                    POL_BEST:  pos = gap_pick(cnt, 1);
                    POL_WORST: pos = gap_pick(cnt, 0);
                    default:   pos = NUM_UNITS;
                endcase
                if (pos < NUM_UNITS)
                begin
                    for (int unsigned k = pos; k < pos + cnt; k++)
                        used[k] = 1;
                    r.ok = 1;
                    r.start_unit = START_W'(pos);
                end
            end
            pending = {pending, r};
        endfunction

        // Compares one strobed response with the oldest expectation.
        function void check_resp(logic a_ok, logic [START_W-1:0] a_st,
                                 logic [COUNT_W-1:0] a_cnt);
            alloc_resp_t r;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response ok=%0d start=%0d count=%0d",
                             a_ok, a_st, a_cnt);
                return;
            end
            r = pending.pop_front();
            if (r.ok !== a_ok || r.start_unit !== a_st || r.unit_count !== a_cnt)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp ok=%0d start=%0d count=%0d, ",
                              "got ok=%0d start=%0d count=%0d"},
                             r.ok, r.start_unit, r.unit_count, a_ok, a_st, a_cnt);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                func;
    logic [SIZE_W-1:0]   size_bytes;
    logic [START_W-1:0]  free_start;
    logic                done;
    logic                ok;
    logic [START_W-1:0]  start_unit;
    logic [COUNT_W-1:0]  unit_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [USIZE_W-1:0]  cfg_data;

    alloc_scoreboard     sb;
    int                  idle_cycles;
    int                  items_sent;
    bit                  timed_out;

    bitmap_fit_allocator #(.UNITS(NUM_UNITS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .size_bytes(size_bytes), .free_start(free_start),
        .done(done), .ok(ok), .start_unit(start_unit), .unit_count(unit_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check responses and watch for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_resp(ok, start_unit, unit_count);
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT && !timed_out)
            begin
                timed_out = 1;
                $display("watchdog: no activity, %0d responses outstanding",
                         sb.pending.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Random gap, mostly short with a few long ones.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        repeat (n) @(negedge clk);
    endtask

    // Sends one item and waits for the beat to be taken.
    task automatic send_item(logic fn, logic [SIZE_W-1:0] sz, logic [START_W-1:0] fs);
        start <= 1'b1;
        func <= fn;
        size_bytes <= sz;
        free_start <= fs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(fn, sz, fs);
        items_sent++;
        @(negedge clk);
        start <= 1'b0;
        @(negedge clk);
    endtask

    // Lets the block drain, then writes one register.
    task automatic write_reg(logic idx, logic [USIZE_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly small requests, an occasional huge one, and frees across the map.
    task automatic random_item();
        logic [SIZE_W-1:0] sz;
        int unsigned us;
        us = (sb.unit_bytes == 0) ? 1 : sb.unit_bytes;
        case ($urandom_range(0, 9))
            0:       sz = SIZE_W'($urandom);
            1:       sz = '0;
            default: sz = SIZE_W'($urandom_range(1, 12 * us > 1048575 ? 1048575 : 12 * us));
        endcase
        send_item(($urandom_range(0, 2) == 0) ? FUNC_FREE : FUNC_ALLOC, sz,
                  START_W'($urandom_range(0, 63)));
        if ($urandom_range(0, 3) == 0)
            idle_gap();
    endtask

    initial
    begin
        logic [15:0] unit_choices[6];
        sb = new();
        idle_cycles = 0;
        items_sent = 0;
        timed_out = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_ALLOC;
        size_bytes = '0;
        free_start = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_POLICY;
        cfg_data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: policy none at reset, then each policy and edge sizes.
        send_item(FUNC_ALLOC, 20'd32, 6'd0);
        write_reg(REG_POLICY, USIZE_W'(POL_FIRST));
        send_item(FUNC_ALLOC, 20'd0, 6'd0);
        send_item(FUNC_ALLOC, 20'd1, 6'd0);
        send_item(FUNC_ALLOC, 20'd17, 6'd0);
        send_item(FUNC_ALLOC, 20'hFFFFF, 6'd0);
        send_item(FUNC_FREE, 20'd16, 6'd0);
        send_item(FUNC_FREE, 20'd0, 6'd5);
        send_item(FUNC_FREE, 20'hFFFFF, 6'd63);
        write_reg(REG_UNIT, 16'd0);
        send_item(FUNC_ALLOC, 20'd64, 6'd0);
        send_item(FUNC_ALLOC, 20'd1, 6'd0);
        send_item(FUNC_FREE, 20'd64, 6'd0);
        write_reg(REG_UNIT, 16'hFFFF);
        send_item(FUNC_ALLOC, 20'hFFFFF, 6'd0);
        write_reg(REG_UNIT, 16'd4);
        write_reg(REG_POLICY, USIZE_W'(POL_NEXT));
        send_item(FUNC_ALLOC, 20'd40, 6'd0);
        send_item(FUNC_ALLOC, 20'd200, 6'd0);
        send_item(FUNC_FREE, 20'd8, 6'd2);
        send_item(FUNC_ALLOC, 20'd8, 6'd0);
        write_reg(REG_POLICY, USIZE_W'(POL_BEST));
        send_item(FUNC_ALLOC, 20'd4, 6'd0);
        write_reg(REG_POLICY, USIZE_W'(POL_WORST));
        send_item(FUNC_ALLOC, 20'd4, 6'd0);
        write_reg(REG_POLICY, USIZE_W'(3'd7));
        send_item(FUNC_ALLOC, 20'd4, 6'd0);
        send_item(FUNC_FREE, 20'd256, 6'd0);

        // Random phases across policies and unit sizes.
        unit_choices = '{16'd1, 16'd3, 16'd16, 16'd64, 16'd1000, 16'hFFFF};
        for (int ph = 0; ph < 24; ph++)
        begin
            write_reg(REG_POLICY, (ph % 8 == 7) ? USIZE_W'($urandom_range(5, 7))
                                                : USIZE_W'($urandom_range(0, 4)));
            write_reg(REG_UNIT, unit_choices[$urandom_range(0, 5)]);
            repeat (20)
                random_item();
            // Occasionally wait out every outstanding response.
            if (ph % 5 == 2)
                drain();
        end

        drain();
        repeat (200) @(negedge clk);
        $display("covered %0d items over all fit policies and unit sizes, %0d responses",
                 items_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d responses missing", sb.mismatches,
                     sb.pending.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/bfa_pkg.sv
rtl/core/bfa_cell.sv
rtl/core/bfa_div.sv
rtl/core/bitmap_fit_allocator.sv
tb/bitmap_fit_allocator_test.sv
